/* rtl/ksf_pkg.sv */
// Shared types, scancode constants and the set-1 to ASCII translation for the scancode FIFO.
package ksf_pkg;

  typedef enum logic {
    CMD_KEY  = 1'b0,
    CMD_READ = 1'b1
  } ksf_cmd_t;

  localparam logic [7:0] SC_ENTER     = 8'h1C;
  localparam logic [7:0] SC_BACKSPACE = 8'h0E;
  localparam logic [7:0] SC_SPACE     = 8'h39;
  localparam logic [7:0] SC_ZERO      = 8'h0B;
  localparam logic [7:0] SC_PERIOD    = 8'h34;
  localparam logic [7:0] SC_SLASH     = 8'h35;

  localparam logic [6:0] CHAR_NONE = 7'h00;

  // Returns the ASCII code of a set-1 make code, or CHAR_NONE if it does not translate.
  function automatic logic [6:0] ksf_to_ascii(input logic [7:0] sc);
    logic [6:0] ch;
    ch = CHAR_NONE;
    case (sc)
      8'h02: ch = 7'h31;
      8'h03: ch = 7'h32;
      8'h04: ch = 7'h33;
      8'h05: ch = 7'h34;
      8'h06: ch = 7'h35;
      8'h07: ch = 7'h36;
      8'h08: ch = 7'h37;
      8'h09: ch = 7'h38;
      8'h0A: ch = 7'h39;
      SC_ZERO: ch = 7'h30;
      8'h10: ch = 7'h71;
      8'h11: ch = 7'h77;
      8'h12: ch = 7'h65;
      8'h13: ch = 7'h72;
      8'h14: ch = 7'h74;
      8'h15: ch = 7'h79;
      8'h16: ch = 7'h75;
      8'h17: ch = 7'h69;
      8'h18: ch = 7'h6F;
      8'h19: ch = 7'h70;
      8'h1E: ch = 7'h61;
      8'h1F: ch = 7'h73;
      8'h20: ch = 7'h64;
      8'h21: ch = 7'h66;
      8'h22: ch = 7'h67;
      8'h23: ch = 7'h68;
      8'h24: ch = 7'h6A;
      8'h25: ch = 7'h6B;
      8'h26: ch = 7'h6C;
      8'h2C: ch = 7'h7A;
      8'h2D: ch = 7'h78;
      8'h2E: ch = 7'h63;
      8'h2F: ch = 7'h76;
      8'h30: ch = 7'h62;
      8'h31: ch = 7'h6E;
      8'h32: ch = 7'h6D;
      SC_SPACE: ch = 7'h20;
      SC_ENTER, SC_BACKSPACE: ch = 7'h0A;
      SC_PERIOD: ch = 7'h2E;
      SC_SLASH: ch = 7'h2F;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/ksf_char_ram.sv */
// Character store: one write port and one registered, enabled read port.
module ksf_char_ram #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [6:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [6:0]    rd_data
);

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/keyboard_scancode_fifo.sv */
// Top level of the scancode FIFO: translates key words into a character ring and pops on read.
//
//   channel  valid      stall      payload
//   in       in_valid   in_stall   cmd, scancode
//   out      out_valid  out_stall  read_char, stored, fill_level
//
// Each word produces one result word through the memory-read stage and the result register,
// and a new word can be accepted every cycle while the output keeps draining.
// The memory-read stage is there because the read port of the character memory is registered.
// Reset clears the pointers, the fill count and all valid flags; the memory is not cleared.
// A stall on the output holds the result register and then the memory-read stage,
// which in turn raises in_stall.
module keyboard_scancode_fifo #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] scancode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] read_char,
  output logic       stored,
  output logic [8:0] fill_level
);
  import ksf_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic [PW-1:0] read_pointer;
  logic [PW-1:0] write_pointer;
  logic [CW-1:0] held_count;
  logic [CW-1:0] held_count_next;
  logic [31:0]   count_wide;

  logic       s1_valid;
  logic       s1_pop;
  logic       s1_stored;
  logic [8:0] s1_fill;

  logic       accept;
  logic       s1_advance;
  logic [6:0] key_char;
  logic       push;
  logic       pop;
  logic [6:0] ram_rd_data;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign accept     = in_valid && !in_stall;

  assign key_char = ksf_to_ascii(scancode);
  assign push = accept && (cmd == CMD_KEY) && (key_char != CHAR_NONE)
                && (held_count != CW'(BUFFER_DEPTH));
  assign pop  = accept && (cmd == CMD_READ) && (held_count != '0);

  always_comb begin
    held_count_next = held_count;
    if (push) begin
      held_count_next = held_count + 1'b1;
    end else if (pop) begin
      held_count_next = held_count - 1'b1;
    end
  end

  assign count_wide = 32'(held_count_next);

  ksf_char_ram #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (write_pointer),
    .wr_data (key_char),
    .rd_en   (pop),
    .rd_addr (read_pointer),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      held_count    <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      held_count <= held_count_next;
      if (push) begin
        write_pointer <= (write_pointer == PW'(BUFFER_DEPTH - 1)) ? '0
                         : write_pointer + 1'b1;
      end
      if (pop) begin
        read_pointer <= (read_pointer == PW'(BUFFER_DEPTH - 1)) ? '0
                        : read_pointer + 1'b1;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop    <= pop;
      s1_stored <= push;
      s1_fill   <= count_wide[8:0];
    end
    if (s1_advance) begin
      read_char  <= s1_pop ? ram_rd_data : CHAR_NONE;
      stored     <= s1_stored;
      fill_level <= s1_fill;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(BUFFER_DEPTH))
    else $error("fill count exceeds buffer depth");

  a_pointers_bounded: assert property (@(posedge clk) disable iff (rst)
    (read_pointer <= PW'(BUFFER_DEPTH - 1)) && (write_pointer <= PW'(BUFFER_DEPTH - 1)))
    else $error("ring pointer out of range");

  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> !accept)
    else $error("word accepted while the read stage is blocked");

  a_push_pop_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(push && pop))
    else $error("push and pop in the same cycle");

  a_pop_moves_pointer: assert property (@(posedge clk) disable iff (rst)
    (pop && BUFFER_DEPTH > 1) |=> (read_pointer != $past(read_pointer)))
    else $error("read pointer did not advance on pop");

endmodule

/* test/tb.sv */
// Self-checking testbench for keyboard_scancode_fifo with a scoreboard class and random traffic.
module tb;
  import ksf_pkg::*;

  localparam int DEPTH        = 256;
  localparam int RANDOM_ITEMS = 1230;
  localparam int LONG_HOLD    = 300;
  localparam int LIMIT        = 400000;
  localparam int SETTLE       = 10;

  localparam logic [7:0] SC_ONE  = 8'h02;
  localparam logic [7:0] SC_NINE = 8'h0A;
  localparam logic [7:0] SC_Q    = 8'h10;
  localparam logic [7:0] SC_P    = 8'h19;
  localparam logic [7:0] SC_A    = 8'h1E;
  localparam logic [7:0] SC_L    = 8'h26;
  localparam logic [7:0] SC_Z    = 8'h2C;
  localparam logic [7:0] SC_M    = 8'h32;
  localparam logic [7:0] SC_NULL = 8'h00;
  localparam logic [7:0] SC_ESC  = 8'h01;
  localparam logic [7:0] SC_BRK  = 8'h80;
  localparam logic [7:0] SC_MAX  = 8'hFF;

  localparam logic [6:0] ASC_NEWLINE = 7'h0A;
  localparam logic [6:0] ASC_SPACE   = 7'h20;
  localparam logic [6:0] ASC_PERIOD  = 7'h2E;
  localparam logic [6:0] ASC_SLASH   = 7'h2F;
  localparam logic [6:0] ASC_ZERO    = 7'h30;
  localparam logic [6:0] ASC_ONE     = 7'h31;

  typedef struct packed {
    logic [6:0] read_char;
    logic       stored;
    logic [8:0] fill_level;
  } ksf_result_t;

  class ksf_scoreboard;
    logic [6:0]  chars [DEPTH];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    int unsigned held;
    int unsigned errors;
    ksf_result_t expected_q[$];

    function new();
      rd_ptr = 0;
      wr_ptr = 0;
      held   = 0;
      errors = 0;
    endfunction

    static function logic [6:0] ascii_of(logic [7:0] sc);
      string top;
      string home;
      string bottom;
      byte   c;
      top    = "qwertyuiop";
      home   = "asdfghjkl";
      bottom = "zxcvbnm";
      c      = 0;
      if (sc >= SC_Q && sc <= SC_P) c = top[int'(sc - SC_Q)];
      else if (sc >= SC_A && sc <= SC_L) c = home[int'(sc - SC_A)];
      else if (sc >= SC_Z && sc <= SC_M) c = bottom[int'(sc - SC_Z)];
      else if (sc >= SC_ONE && sc <= SC_NINE) return ASC_ONE + 7'(sc - SC_ONE);
      else if (sc == SC_ZERO) return ASC_ZERO;
      else if (sc == SC_SPACE) return ASC_SPACE;
      else if (sc == SC_ENTER || sc == SC_BACKSPACE) return ASC_NEWLINE;
      else if (sc == SC_PERIOD) return ASC_PERIOD;
      else if (sc == SC_SLASH) return ASC_SLASH;
      return 7'(c);
    endfunction

    function void note_word(ksf_cmd_t c, logic [7:0] sc);
      ksf_result_t r;
      logic [6:0]  ch;
      r = '0;
      if (c == CMD_KEY) begin
        ch = ascii_of(sc);
        if (ch != CHAR_NONE && held < DEPTH) begin
          chars[wr_ptr] = ch;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          held++;
          r.stored = 1'b1;
        end
      end else if (held != 0) begin
        r.read_char = chars[rd_ptr];
        rd_ptr = (rd_ptr + 1) % DEPTH;
        held--;
      end
      r.fill_level = 9'(held);
      expected_q.push_back(r);
    endfunction

    function void check_word(ksf_result_t got);
      ksf_result_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected word: read_char %0h stored %0b fill_level %0d",
               got.read_char, got.stored, got.fill_level);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.read_char !== exp.read_char) begin
        $error("read_char: expected %0h, got %0h", exp.read_char, got.read_char);
        errors++;
      end
      if (got.stored !== exp.stored) begin
        $error("stored: expected %0b, got %0b", exp.stored, got.stored);
        errors++;
      end
      if (got.fill_level !== exp.fill_level) begin
        $error("fill_level: expected %0d, got %0d", exp.fill_level, got.fill_level);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       cmd;
  logic [7:0] scancode;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] read_char;
  logic       stored;
  logic [8:0] fill_level;

  ksf_scoreboard model;
  logic [7:0]    key_codes[$];
  bit            want_hold;
  bit            gaps_on;
  int            burst_left;
  int            cycle_count;

  keyboard_scancode_fifo #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .scancode(scancode),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_char(read_char),
    .stored(stored),
    .fill_level(fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) model.note_word(ksf_cmd_t'(cmd), scancode);
      if (out_valid && !out_stall) model.check_word({read_char, stored, fill_level});
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int mode;
    int len;
    wait (rst === 1'b0);
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(5, 80);
        repeat (len) begin
          @(negedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  task automatic put_word(ksf_cmd_t c, logic [7:0] sc);
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= c;
    scancode <= sc;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (model.expected_q.size() != 0) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic send_word(ksf_cmd_t c, logic [7:0] sc);
    if (burst_left == 0) begin
      if (gaps_on) idle_cycles($urandom_range(1, 15));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    put_word(c, sc);
  endtask

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return SC_NULL;
    if (r < 25) return 8'($urandom_range(0, 255));
    return key_codes[$urandom_range(0, key_codes.size() - 1)];
  endfunction

  initial begin
    logic [7:0] directed_keys[$];
    int         sent;
    int         seg;
    int         len;
    int         pct;
    model      = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = CMD_KEY;
    scancode   = 8'h00;
    out_stall  = 1'b0;
    want_hold  = 1'b0;
    gaps_on    = 1'b1;
    burst_left = 0;
    for (int i = 0; i < 256; i++)
      if (ksf_scoreboard::ascii_of(8'(i)) != CHAR_NONE) key_codes.push_back(8'(i));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_keys = '{SC_NULL, SC_BRK, SC_MAX, SC_ESC, SC_ENTER, SC_BACKSPACE, SC_SPACE,
                      SC_PERIOD, SC_SLASH, SC_ZERO, SC_ONE, SC_NINE, SC_Q, SC_P, SC_A,
                      SC_L, SC_Z, SC_M};
    put_word(CMD_READ, SC_MAX);
    foreach (directed_keys[i]) put_word(CMD_KEY, directed_keys[i]);
    repeat (4) put_word(CMD_READ, SC_NULL);
    wait_drained();

    sent = 0;
    seg  = 0;
    while (sent < RANDOM_ITEMS) begin
      if (seg == 0) begin
        len = 400;
        pct = 95;
      end else if (seg == 1) begin
        len = 400;
        pct = 10;
      end else begin
        len = $urandom_range(40, 200);
        case ($urandom_range(0, 2))
          0: pct = 90;
          1: pct = 50;
          default: pct = 10;
        endcase
      end
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      if (seg == 1 || $urandom_range(0, 9) == 0) want_hold = 1'b1;
      gaps_on = ($urandom_range(0, 4) != 0);
      repeat (len) begin
        if ($urandom_range(0, 99) < pct) send_word(CMD_KEY, pick_key());
        else send_word(CMD_READ, 8'($urandom_range(0, 255)));
      end
      sent += len;
      seg++;
      if (seg == 1 || $urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (model.errors == 0 && model.expected_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
